[rtl/core/falr_pkg.sv]
`default_nettype none

package falr_pkg;

  localparam int unsigned MAX_LABELS = 64;
  localparam int unsigned LabelW     = 32;
  localparam int unsigned CanonW     = 7;
  localparam int unsigned AddrW      = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int unsigned CntW       = $clog2(MAX_LABELS + 1);

  typedef struct packed {
    logic start;
    logic scan;
    logic finish;
  } falr_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } falr_status_t;

endpackage

`default_nettype wire

[rtl/core/falr_ctrl.sv]
`default_nettype none

module falr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  falr_pkg::falr_status_t status_i,
  output falr_pkg::falr_cmd_t    cmd_o
);
  import falr_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d      = state_q;
    cmd_o.start  = 1'b0;
    cmd_o.scan   = 1'b0;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = StScan;
        end
      end
      StScan: begin
        if (!status_i.done) begin
          cmd_o.scan = 1'b1;
        end else if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/falr_datapath.sv]
`default_nettype none

module falr_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  falr_pkg::falr_cmd_t            cmd_i,
  output falr_pkg::falr_status_t         status_o,
  input  logic [falr_pkg::LabelW-1:0]    raw_label_i,
  input  logic                           end_of_partition_i,
  output logic [falr_pkg::CanonW-1:0]    canonical_label_o,
  output logic                           first_seen_o,
  output logic                           table_overflow_o,
  output logic                           end_echo_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i
);
  import falr_pkg::*;

  logic [LabelW-1:0] mem_q [MAX_LABELS];

  logic [LabelW-1:0] label_q;
  logic              last_q;
  logic [CntW-1:0]   cnt_q;
  logic [CntW-1:0]   addr_q;
  logic [LabelW-1:0] rd_q;
  logic [AddrW-1:0]  rd_idx_q;
  logic              rd_vld_q;
  logic              out_valid_q;

  logic              match;
  logic              exhausted;
  logic              issue;
  logic              room;
  logic [CntW-1:0]   hit_num;
  logic [CntW-1:0]   new_num;

  assign match     = rd_vld_q && (rd_q == label_q);
  assign exhausted = (addr_q >= cnt_q) && !match;
  assign issue     = cmd_i.scan && (addr_q < cnt_q);
  assign room      = (cnt_q < CntW'(MAX_LABELS));
  assign hit_num   = CntW'(rd_idx_q) + CntW'(1);
  assign new_num   = cnt_q + CntW'(1);

  assign status_o.done     = match || exhausted;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q     <= mem_q[addr_q[AddrW-1:0]];
      rd_idx_q <= addr_q[AddrW-1:0];
    end
    if (cmd_i.finish && !match && room) begin
      mem_q[cnt_q[AddrW-1:0]] <= label_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      label_q <= raw_label_i;
      last_q  <= end_of_partition_i;
    end
    if (cmd_i.finish) begin
      end_echo_o <= last_q;
      if (match) begin
        canonical_label_o <= CanonW'(hit_num);
        first_seen_o      <= 1'b0;
        table_overflow_o  <= 1'b0;
      end else if (room) begin
        canonical_label_o <= CanonW'(new_num);
        first_seen_o      <= 1'b1;
        table_overflow_o  <= 1'b0;
      end else begin
        canonical_label_o <= '0;
        first_seen_o      <= 1'b0;
        table_overflow_o  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      addr_q      <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        addr_q   <= '0;
        rd_vld_q <= 1'b0;
      end else if (cmd_i.scan) begin
        rd_vld_q <= issue;
        if (issue) begin
          addr_q <= addr_q + CntW'(1);
        end
      end

      if (cmd_i.finish) begin
        if (last_q) begin
          cnt_q <= '0;
        end else if (!match && room) begin
          cnt_q <= new_num;
        end
      end

      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/first_appearance_label_renumber.sv]
// A new request is taken only once the previous scan has ended and its result has been
//   loaded into the output register; N = labels stored so far (0..64).
// Scan is one entry per cycle over the N stored entries; a hit in entry k ends it early.
//   The result is loaded only once the output register is free (out_ready_i).
// A waiting result sits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous): table empty, numbering restarts at 1, no result pending.
`default_nettype none

module first_appearance_label_renumber (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [falr_pkg::LabelW-1:0] raw_label_i,
  input  logic                        end_of_partition_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [falr_pkg::CanonW-1:0] canonical_label_o,
  output logic                        first_seen_o,
  output logic                        table_overflow_o,
  output logic                        end_echo_o
);
  import falr_pkg::*;

  falr_cmd_t    cmd;
  falr_status_t status;

  falr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  falr_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .raw_label_i        (raw_label_i),
    .end_of_partition_i (end_of_partition_i),
    .canonical_label_o  (canonical_label_o),
    .first_seen_o       (first_seen_o),
    .table_overflow_o   (table_overflow_o),
    .end_echo_o         (end_echo_o),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i)
  );

  a_fresh_not_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(first_seen_o && table_overflow_o))
    else $error("first_seen and table_overflow both set");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && table_overflow_o) |-> (canonical_label_o == '0))
    else $error("overflow result carries a nonzero label");

  a_fresh_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && first_seen_o) |-> (canonical_label_o != '0))
    else $error("new label got number zero");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while previous still in scan");

endmodule

`default_nettype wire

[tb/tb_top.sv]
module tb_top;

  import falr_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 80;

  typedef struct packed {
    logic [CanonW-1:0] canon;
    logic              fresh;
    logic              ovf;
    logic              eop;
  } answer_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [LabelW-1:0] raw_label_i;
  logic              end_of_partition_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [CanonW-1:0] canonical_label_o;
  logic              first_seen_o;
  logic              table_overflow_o;
  logic              end_echo_o;

  logic [LabelW-1:0] known_labels [MAX_LABELS];
  logic              known_valid  [MAX_LABELS];
  int unsigned       next_canon;

  answer_t     pending_answers[$];
  int unsigned fail_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  first_appearance_label_renumber DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .raw_label_i        (raw_label_i),
    .end_of_partition_i (end_of_partition_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .canonical_label_o  (canonical_label_o),
    .first_seen_o       (first_seen_o),
    .table_overflow_o   (table_overflow_o),
    .end_echo_o         (end_echo_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_partition();
    for (int i = 0; i < MAX_LABELS; i++) begin
      known_valid[i] = 1'b0;
    end
    next_canon = 1;
  endfunction

  function automatic answer_t renumber_label(logic [LabelW-1:0] lbl, logic eop);
    answer_t ans;
    bit      hit;
    ans = '0;
    hit = 1'b0;
    for (int i = 0; i < MAX_LABELS; i++) begin
      if (!hit && known_valid[i] && known_labels[i] == lbl) begin
        ans.canon = CanonW'(i + 1);
        hit = 1'b1;
      end
    end
    if (!hit) begin
      if (next_canon <= MAX_LABELS) begin
        known_labels[next_canon - 1] = lbl;
        known_valid[next_canon - 1]  = 1'b1;
        ans.canon = CanonW'(next_canon);
        ans.fresh = 1'b1;
        next_canon++;
      end else begin
        ans.ovf = 1'b1;
      end
    end
    ans.eop = eop;
    if (eop) clear_partition();
    return ans;
  endfunction

  // call right after a rising edge; returns at the edge that takes the request
  task automatic send_label(input logic [LabelW-1:0] lbl, input logic eop);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    raw_label_i        <= lbl;
    end_of_partition_i <= eop;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_answers.push_back(renumber_label(lbl, eop));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_extremes();
    send_label(32'h0000_0000, 1'b0);
    send_label(32'hFFFF_FFFF, 1'b0);
    send_label(32'h0000_0000, 1'b0);
    send_label(32'h8000_0000, 1'b0);
    send_label(32'h0000_0001, 1'b0);
    send_label(32'hFFFF_FFFF, 1'b0);
    send_label(32'h7FFF_FFFF, 1'b1);
    // lone request that ends its partition
    send_label(32'hFFFF_FFFF, 1'b1);
    send_label(32'h0000_0001, 1'b0);
    send_label(32'h0000_0001, 1'b1);
    send_label(32'h0000_0001, 1'b0);
    send_label(32'hFFFF_FFFE, 1'b1);
    wait_drained();
  endtask

  task automatic test_table_full();
    logic [LabelW-1:0] base;
    logic [LabelW-1:0] step;
    base = $urandom;
    step = $urandom | 32'h1;
    for (int i = 0; i < MAX_LABELS; i++) begin
      send_label(base + step * i, 1'b0);
    end
    send_label(base + step * MAX_LABELS, 1'b0);
    send_label(base + step * (MAX_LABELS + 1), 1'b0);
    send_label(base + step * MAX_LABELS, 1'b0);
    send_label(base, 1'b0);
    send_label(base + step * (MAX_LABELS - 1), 1'b0);
    send_label(base + step * MAX_LABELS, 1'b1);
    send_label(base + step * MAX_LABELS, 1'b0);
    send_label(base, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_partitions(input int unsigned n_items);
    int unsigned       sent;
    int unsigned       part_len;
    int unsigned       pool_n;
    int unsigned       mode;
    logic [LabelW-1:0] pool[$];
    logic [LabelW-1:0] lbl;
    sent = 0;
    while (sent < n_items) begin
      mode = $urandom_range(99);
      if (mode < 8) begin
        part_len = $urandom_range(70, 100);
        pool_n   = $urandom_range(62, 90);
      end else begin
        part_len = (mode < 15) ? 1 : $urandom_range(2, 30);
        pool_n   = $urandom_range(1, part_len);
      end
      pool.delete();
      for (int k = 0; k < pool_n; k++) begin
        pool.push_back(($urandom_range(3) == 0) ? $urandom_range(0, 15) : $urandom);
      end
      for (int k = 0; k < part_len; k++) begin
        if ($urandom_range(19) == 0) lbl = $urandom;
        else if (mode < 8 && k < pool_n) lbl = pool[k];
        else lbl = pool[$urandom_range(pool_n - 1)];
        send_label(lbl, k == part_len - 1);
        sent++;
      end
    end
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      if (out_valid_o && out_ready_i) begin
        if (pending_answers.size() == 0) begin
          $error("unexpected result: canonical_label %0d", canonical_label_o);
          fail_count++;
        end else begin
          answer_t exp_ans;
          exp_ans = pending_answers.pop_front();
          if (canonical_label_o !== exp_ans.canon) begin
            $error("canonical_label: expected %0d, got %0d", exp_ans.canon, canonical_label_o);
            fail_count++;
          end
          if (first_seen_o !== exp_ans.fresh) begin
            $error("first_seen: expected %0b, got %0b", exp_ans.fresh, first_seen_o);
            fail_count++;
          end
          if (table_overflow_o !== exp_ans.ovf) begin
            $error("table_overflow: expected %0b, got %0b", exp_ans.ovf, table_overflow_o);
            fail_count++;
          end
          if (end_echo_o !== exp_ans.eop) begin
            $error("end_echo: expected %0b, got %0b", exp_ans.eop, end_echo_o);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[first_appearance_label_renumber] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    raw_label_i        = '0;
    end_of_partition_i = 1'b0;
    out_ready_i        = 1'b0;
    fail_count         = 0;
    quiet_cycles       = 0;
    send_idle_pct      = 17;
    recv_idle_pct      = 62;
    clear_partition();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_table_full();
    test_random_partitions(500);

    send_idle_pct = 62;
    recv_idle_pct = 17;
    test_random_partitions(550);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_table_full();
    test_random_partitions(480);

    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("[first_appearance_label_renumber] OK");
    end else begin
      $display("[first_appearance_label_renumber] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/falr_pkg.sv
rtl/core/falr_ctrl.sv
rtl/core/falr_datapath.sv
rtl/core/first_appearance_label_renumber.sv
tb/tb_top.sv
